FILE: sv/session_key_cache_table_unit_macros.svh
// assertion macros for the session key cache table rtl
// used by session_key_cache_table_unit.sv, which checks its own logic; no other dependencies
`ifndef SESSION_KEY_CACHE_TABLE_UNIT_MACROS_SVH
`define SESSION_KEY_CACHE_TABLE_UNIT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define SKCT_ASSERT_IMP(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("skct check failed");

// next-cycle implication, disabled while reset is asserted
`define SKCT_ASSERT_NXT(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("skct check failed");

`endif

FILE: sv/skct_pkg.sv
// shared types and constants for the session key cache table
// no dependencies
`default_nettype none

package skct_pkg;

	localparam int DEF_TABLE_SLOTS = 128;
	localparam int DEF_ID_BYTES    = 8;

	localparam int ID_W     = 64;
	localparam int REF_W    = 32;
	localparam int LEN_W    = 8;
	localparam int SLOT_W   = 7;
	localparam int COUNT_W  = 8;
	localparam int STATUS_W = 2;
	localparam int CFG_W    = 7;
	localparam int CFG_IDX_W = 1;

	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_LOOKUP = 1'b1;

	localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_ZERO_LEN  = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_FULL_POLICY = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_VICTIM_SLOT = 1'd1;

	localparam logic              FULL_POLICY_RST = 1'b1;
	localparam logic [SLOT_W-1:0] VICTIM_SLOT_RST = 7'd90;

	// search token handed from cell to cell
	typedef struct packed {
		logic             active;
		logic             done;
		logic [REF_W-1:0] psk_ref;
		logic [LEN_W-1:0] psk_len;
	} carry_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

FILE: sv/skct_cell.sv
// one table slot: holds valid, key, reference and length, and passes the
// search token on to the next slot; depends on skct_pkg
`default_nettype none

module skct_cell #(
	parameter int IW = 7,
	parameter int KW = 64,
	parameter logic [IW-1:0] CELL_IDX = '0
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      is_lookup,
	input  wire logic [KW-1:0]             key,
	input  wire logic [skct_pkg::REF_W-1:0] wr_ref,
	input  wire logic [skct_pkg::LEN_W-1:0] wr_len,
	input  wire logic                      vict_we,
	input  wire logic [IW-1:0]             vict_idx,
	input  wire skct_pkg::carry_t          carry_in,
	input  wire logic [IW-1:0]             slot_in,
	output skct_pkg::carry_t               carry_out,
	output logic [IW-1:0]                  slot_out,
	output logic                           valid,
	output logic                           hit
);
	import skct_pkg::*;

	logic             valid_q;
	logic [KW-1:0]    key_q;
	logic [REF_W-1:0] ref_q;
	logic [LEN_W-1:0] len_q;
	carry_t           carry_q;
	logic [IW-1:0]    slot_q;
	logic             match;
	logic             wr_here;

	always_comb begin
		match = carry_in.active && !carry_in.done &&
			(is_lookup ? (valid_q && (key_q == key)) : !valid_q);
		wr_here = (match && !is_lookup) || (vict_we && (vict_idx == CELL_IDX));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (wr_here) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_here) begin
			key_q <= key;
			ref_q <= wr_ref;
			len_q <= wr_len;
		end
	end

	// the first matching slot marks the token done and loads its data into it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			carry_q <= '0;
			slot_q  <= '0;
		end else begin
			carry_q.active  <= carry_in.active;
			carry_q.done    <= carry_in.done | match;
			carry_q.psk_ref <= match ? ref_q : carry_in.psk_ref;
			carry_q.psk_len <= match ? len_q : carry_in.psk_len;
			slot_q          <= match ? CELL_IDX : slot_in;
		end
	end

	assign carry_out = carry_q;
	assign slot_out  = slot_q;
	assign valid     = valid_q;
	assign hit       = match;

endmodule

`default_nettype wire

FILE: sv/session_key_cache_table_unit.sv
// Session key cache table: TABLE_SLOTS slots, each holding a session
// identifier, a key buffer reference and a key length, built as a row of
// slot cells. A request is one transaction: an insert writes the lowest free
// slot (or, when full, refuses or overwrites the configured victim slot), a
// lookup returns the lowest occupied slot whose identifier matches. Each
// lookup and each insert of nonzero length walks a search token down the cell
// row one slot per clock; a zero-length insert is refused without a scan.
// One request is in the table at a time; the result sits in an output register
// so the next request is accepted while it waits to be taken. The table comes
// out of reset empty and ready, with no clearing pass. Configuration writes
// go through the plain write port and must be made while the block is idle.
// Depends on skct_pkg, skct_cell and session_key_cache_table_unit_macros.svh.
`default_nettype none
`include "session_key_cache_table_unit_macros.svh"

module session_key_cache_table_unit #(
	parameter int TABLE_SLOTS = skct_pkg::DEF_TABLE_SLOTS,
	parameter int ID_BYTES    = skct_pkg::DEF_ID_BYTES
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_wr_en,
	input  wire logic [skct_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [skct_pkg::CFG_W-1:0]     cfg_wdata,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic                          req_type,
	input  wire logic [skct_pkg::ID_W-1:0]      sess_id,
	input  wire logic [skct_pkg::REF_W-1:0]     psk_ref,
	input  wire logic [skct_pkg::LEN_W-1:0]     psk_len,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [skct_pkg::STATUS_W-1:0]       status,
	output logic [skct_pkg::SLOT_W-1:0]         slot,
	output logic [skct_pkg::REF_W-1:0]          found_ref,
	output logic [skct_pkg::LEN_W-1:0]          found_len,
	output logic                               evicted,
	output logic [skct_pkg::COUNT_W-1:0]        free_count
);
	import skct_pkg::*;

	localparam int IW = $clog2(TABLE_SLOTS);
	localparam int KW = 8 * ID_BYTES;
	localparam int FW = $clog2(TABLE_SLOTS + 1);
	localparam int VMOD_DEPTH = 2 ** SLOT_W;

	typedef logic [IW-1:0] vmod_t [VMOD_DEPTH];

	function automatic vmod_t build_vmod();
		vmod_t t;
		for (int i = 0; i < VMOD_DEPTH; i++) begin
			t[i] = IW'(i % TABLE_SLOTS);
		end
		return t;
	endfunction

	// victim register reduced modulo the table size
	localparam vmod_t VMOD = build_vmod();

	state_t            state_q, state_nxt;
	logic              full_policy_q;
	logic [SLOT_W-1:0] victim_slot_q;
	logic              req_q;
	logic [KW-1:0]     key_q;
	logic [REF_W-1:0]  ref_q;
	logic [LEN_W-1:0]  len_q;
	logic              start_q;
	logic              res_done_q;
	logic [IW-1:0]     res_slot_q;
	logic [REF_W-1:0]  res_ref_q;
	logic [LEN_W-1:0]  res_len_q;
	logic [FW-1:0]     free_q, free_nxt;

	logic                out_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [REF_W-1:0]    found_ref_q;
	logic [LEN_W-1:0]    found_len_q;
	logic                evicted_q;
	logic [COUNT_W-1:0]  free_count_q;

	carry_t              carry_vec [TABLE_SLOTS+1];
	logic [IW-1:0]       slot_vec  [TABLE_SLOTS+1];
	logic [TABLE_SLOTS-1:0] valid_vec;
	logic [TABLE_SLOTS-1:0] hit_vec;
	logic [TABLE_SLOTS-1:0] active_vec;

	logic                accept;
	logic                zero_in;
	logic                scan_end;
	logic                load;
	logic                vict_we;
	logic                vict_req;
	logic                free_dec;
	logic [STATUS_W-1:0] r_status;
	logic [IW-1:0]       r_slot;
	logic [REF_W-1:0]    r_ref;
	logic [LEN_W-1:0]    r_len;
	logic                r_ev;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_policy_q <= FULL_POLICY_RST;
			victim_slot_q <= VICTIM_SLOT_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_FULL_POLICY: full_policy_q <= cfg_wdata[0];
				CFG_VICTIM_SLOT: victim_slot_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// cell row
	assign carry_vec[0] = '{active: start_q, done: 1'b0, psk_ref: '0, psk_len: '0};
	assign slot_vec[0]  = '0;

	for (genvar g = 0; g < TABLE_SLOTS; g++) begin : g_cell
		skct_cell #(
			.IW(IW),
			.KW(KW),
			.CELL_IDX(IW'(g))
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.is_lookup(req_q),
			.key(key_q),
			.wr_ref(ref_q),
			.wr_len(len_q),
			.vict_we(vict_we),
			.vict_idx(VMOD[victim_slot_q]),
			.carry_in(carry_vec[g]),
			.slot_in(slot_vec[g]),
			.carry_out(carry_vec[g+1]),
			.slot_out(slot_vec[g+1]),
			.valid(valid_vec[g]),
			.hit(hit_vec[g])
		);
		assign active_vec[g] = carry_vec[g+1].active;
	end

	assign scan_end = carry_vec[TABLE_SLOTS].active;
	assign accept   = in_valid && in_ready;
	assign zero_in  = (req_type == REQ_INSERT) && (psk_len == '0);
	assign load     = (state_q == ST_DONE) && (!out_valid_q || out_ready);
	assign vict_we  = load && vict_req;

	// result of the finished request
	always_comb begin
		r_status = STAT_OK;
		r_slot   = '0;
		r_ref    = '0;
		r_len    = '0;
		r_ev     = 1'b0;
		free_dec = 1'b0;
		vict_req = 1'b0;
		if (req_q == REQ_LOOKUP) begin
			if (res_done_q) begin
				r_slot = res_slot_q;
				r_ref  = res_ref_q;
				r_len  = res_len_q;
			end else begin
				r_status = STAT_NOT_FOUND;
			end
		end else if (len_q == '0) begin
			r_status = STAT_ZERO_LEN;
		end else if (res_done_q) begin
			r_slot   = res_slot_q;
			free_dec = 1'b1;
		end else if (!full_policy_q) begin
			r_status = STAT_FULL;
		end else begin
			r_slot   = VMOD[victim_slot_q];
			r_ev     = 1'b1;
			vict_req = 1'b1;
		end
		free_nxt = free_dec ? free_q - FW'(1) : free_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		in_ready  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_nxt = zero_in ? ST_DONE : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_end) begin
					state_nxt = ST_DONE;
				end
			end
			ST_DONE: begin
				if (load) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= 1'b0;
			free_q  <= FW'(TABLE_SLOTS);
		end else begin
			start_q <= accept && !zero_in;
			if (load) begin
				free_q <= free_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req_type;
			key_q <= sess_id[KW-1:0];
			ref_q <= psk_ref;
			len_q <= psk_len;
		end
		// a zero-length insert never scans, so the match flag is cleared here
		if (accept) begin
			res_done_q <= 1'b0;
		end else if ((state_q == ST_SCAN) && scan_end) begin
			res_done_q <= carry_vec[TABLE_SLOTS].done;
		end
		if ((state_q == ST_SCAN) && scan_end) begin
			res_slot_q <= slot_vec[TABLE_SLOTS];
			res_ref_q  <= carry_vec[TABLE_SLOTS].psk_ref;
			res_len_q  <= carry_vec[TABLE_SLOTS].psk_len;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			status_q     <= r_status;
			slot_q       <= SLOT_W'(r_slot);
			found_ref_q  <= r_ref;
			found_len_q  <= r_len;
			evicted_q    <= r_ev;
			free_count_q <= COUNT_W'(free_nxt);
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign slot       = slot_q;
	assign found_ref  = found_ref_q;
	assign found_len  = found_len_q;
	assign evicted    = evicted_q;
	assign free_count = free_count_q;

	`SKCT_ASSERT_IMP(a_free_count_tracks_valid, clk, arst_n, (state_q == ST_IDLE),
		(($countones(valid_vec) + int'(free_q)) == TABLE_SLOTS))
	`SKCT_ASSERT_IMP(a_single_token, clk, arst_n, 1'b1, $onehot0(active_vec))
	`SKCT_ASSERT_IMP(a_single_hit, clk, arst_n, 1'b1, $onehot0(hit_vec))
	`SKCT_ASSERT_NXT(a_scan_end_to_done, clk, arst_n, (state_q == ST_SCAN) && scan_end,
		(state_q == ST_DONE))

endmodule

`default_nettype wire

FILE: tb/session_key_cache_table_unit_test.sv
// testbench for session_key_cache_table_unit: insert and lookup transactions checked
// against a predictor of the slot table, with and without random stalls on both channels
// depends on skct_pkg and the session_key_cache_table_unit rtl
`default_nettype none

module session_key_cache_table_unit_test;
	import skct_pkg::*;

	localparam int SLOTS       = DEF_TABLE_SLOTS;
	localparam int STALL_LIMIT = 4000;
	localparam int TAIL_CYCLES = 140;
	localparam logic [ID_W-1:0] ID_MASK = (DEF_ID_BYTES >= 8) ? {ID_W{1'b1}} :
		((64'd1 << (8 * DEF_ID_BYTES)) - 64'd1);

	typedef struct packed {
		logic              kind;
		logic [ID_W-1:0]   id;
		logic [REF_W-1:0]  key_ref;
		logic [LEN_W-1:0]  key_len;
	} cache_req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [SLOT_W-1:0]   slot;
		logic [REF_W-1:0]    found_ref;
		logic [LEN_W-1:0]    found_len;
		logic                evicted;
		logic [COUNT_W-1:0]  free_count;
	} cache_result_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_wdata;
	logic                 in_valid;
	logic                 in_ready;
	logic                 req_type;
	logic [ID_W-1:0]      sess_id;
	logic [REF_W-1:0]     psk_ref;
	logic [LEN_W-1:0]     psk_len;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [STATUS_W-1:0]  status;
	logic [SLOT_W-1:0]    slot;
	logic [REF_W-1:0]     found_ref;
	logic [LEN_W-1:0]     found_len;
	logic                 evicted;
	logic [COUNT_W-1:0]   free_count;

	// predicted table contents and register values
	bit                 tbl_used [SLOTS];
	logic [ID_W-1:0]    tbl_id [SLOTS];
	logic [REF_W-1:0]   tbl_ref [SLOTS];
	logic [LEN_W-1:0]   tbl_len [SLOTS];
	int                 free_left = SLOTS;
	bit                 cfg_overwrite = FULL_POLICY_RST;
	logic [SLOT_W-1:0]  cfg_victim = VICTIM_SLOT_RST;

	cache_result_t      expected_results [$];
	logic [ID_W-1:0]    stored_ids [$];
	int                 mismatch_count = 0;
	int                 stall_cycles = 0;
	int                 send_idle_pct = 0;
	int                 recv_idle_pct = 0;

	session_key_cache_table_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.req_type   (req_type),
		.sess_id    (sess_id),
		.psk_ref    (psk_ref),
		.psk_len    (psk_len),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.slot       (slot),
		.found_ref  (found_ref),
		.found_len  (found_len),
		.evicted    (evicted),
		.free_count (free_count)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// lowest free slot on insert, victim when full and overwriting, lowest matching slot on lookup
	function automatic cache_result_t predict_cache(cache_req_t r);
		cache_result_t res;
		logic [ID_W-1:0] key;
		int pick;
		int i;
		res = '0;
		pick = -1;
		key = r.id & ID_MASK;
		if (r.kind == REQ_INSERT) begin
			if (r.key_len == '0) begin
				res.status = STAT_ZERO_LEN;
			end else begin
				for (i = 0; i < SLOTS; i++)
					if (pick < 0 && !tbl_used[i])
						pick = i;
				if (pick >= 0) begin
					free_left--;
				end else if (!cfg_overwrite) begin
					res.status = STAT_FULL;
				end else begin
					pick = int'(cfg_victim) % SLOTS;
					res.evicted = 1'b1;
				end
				if (pick >= 0) begin
					tbl_used[pick] = 1'b1;
					tbl_id[pick] = key;
					tbl_ref[pick] = r.key_ref;
					tbl_len[pick] = r.key_len;
					res.slot = pick[SLOT_W-1:0];
				end
			end
		end else begin
			res.status = STAT_NOT_FOUND;
			for (i = 0; i < SLOTS; i++)
				if (pick < 0 && tbl_used[i] && (tbl_id[i] & ID_MASK) == key)
					pick = i;
			if (pick >= 0) begin
				res.status = STAT_OK;
				res.slot = pick[SLOT_W-1:0];
				res.found_ref = tbl_ref[pick];
				res.found_len = tbl_len[pick];
			end
		end
		res.free_count = free_left[COUNT_W-1:0];
		return res;
	endfunction

	function automatic cache_req_t make_req(logic kind, logic [ID_W-1:0] id,
			logic [REF_W-1:0] key_ref, logic [LEN_W-1:0] key_len);
		cache_req_t r;
		r.kind = kind;
		r.id = id;
		r.key_ref = key_ref;
		r.key_len = key_len;
		return r;
	endfunction

	// mostly ids already stored or one bit away from one, some extremes and noise
	function automatic cache_req_t random_request(int insert_pct);
		cache_req_t r;
		int roll;
		int hit_pct;
		r.kind = ($urandom_range(99) < insert_pct) ? REQ_INSERT : REQ_LOOKUP;
		r.key_ref = $urandom;
		roll = $urandom_range(99);
		if (roll < 5)
			r.key_len = '0;
		else if (roll < 10)
			r.key_len = '1;
		else
			r.key_len = LEN_W'($urandom_range(255, 1));
		hit_pct = (r.kind == REQ_LOOKUP) ? 70 : 20;
		roll = $urandom_range(99);
		if (stored_ids.size() > 0 && roll < hit_pct)
			r.id = stored_ids[$urandom_range(stored_ids.size() - 1)];
		else if (stored_ids.size() > 0 && roll < 85)
			r.id = stored_ids[$urandom_range(stored_ids.size() - 1)] ^
				(64'd1 << $urandom_range(ID_W - 1));
		else if (roll < 90)
			r.id = roll[0] ? '0 : '1;
		else
			r.id = {$urandom, $urandom};
		return r;
	endfunction

	// called and returns at a falling edge; valid is left high for back-to-back sends
	task automatic send_request(cache_req_t r);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		req_type <= r.kind;
		sess_id <= r.id;
		psk_ref <= r.key_ref;
		psk_len <= r.key_len;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		expected_results.push_back(predict_cache(r));
		if (r.kind == REQ_INSERT && r.key_len != '0) begin
			stored_ids.push_back(r.id);
			if (stored_ids.size() > 200)
				void'(stored_ids.pop_front());
		end
		@(negedge clk);
	endtask

	task automatic run_random(int count, int insert_pct);
		int n;
		for (n = 0; n < count; n++)
			send_request(random_request(insert_pct));
	endtask

	// wait until every transaction has come back so the block is idle
	task automatic drain_requests();
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		if (idx == CFG_FULL_POLICY)
			cfg_overwrite = data[0];
		else
			cfg_victim = data[SLOT_W-1:0];
		@(negedge clk);
	endtask

	task automatic write_policy(bit overwrite);
		logic [CFG_W-1:0] junk;
		junk = CFG_W'($urandom);
		write_reg(CFG_FULL_POLICY, {junk[CFG_W-1:1], overwrite});
	endtask

	task automatic test_empty_table_cases();
		send_request(make_req(REQ_LOOKUP, '0, '1, '1));
		send_request(make_req(REQ_INSERT, '1, 32'h1234_5678, '0));
		send_request(make_req(REQ_LOOKUP, '1, '0, '0));
		send_request(make_req(REQ_INSERT, '0, '0, 8'd1));
		send_request(make_req(REQ_INSERT, '1, '1, '1));
		send_request(make_req(REQ_INSERT, '0, 32'h1234_5678, 8'd128));
		send_request(make_req(REQ_LOOKUP, '0, '1, '1));
		send_request(make_req(REQ_LOOKUP, '1, '0, '0));
		send_request(make_req(REQ_LOOKUP, 64'h8000_0000_0000_0000, '0, '0));
		send_request(make_req(REQ_INSERT, 64'h8000_0000_0000_0001, 32'hA5A5_A5A5, 8'h80));
		send_request(make_req(REQ_INSERT, 64'h5A5A_5A5A_5A5A_5A5A, 32'h8000_0000, 8'h7F));
		send_request(make_req(REQ_LOOKUP, 64'h8000_0000_0000_0001, '0, '0));
		send_request(make_req(REQ_LOOKUP, 64'h8000_0000_0000_0003, '0, '0));
		send_request(make_req(REQ_LOOKUP, 64'h5A5A_5A5A_5A5A_5A5A, '1, 8'h01));
		// refused zero-length insert must not leave an entry behind
		send_request(make_req(REQ_INSERT, 64'h0123_4567_89AB_CDEF, '1, '0));
		send_request(make_req(REQ_LOOKUP, 64'h0123_4567_89AB_CDEF, '0, '0));
	endtask

	// fills the table and then keeps going on the reset policy and victim
	task automatic test_fill_until_full();
		run_random(330, 60);
	endtask

	task automatic test_full_refusal();
		logic [CFG_W-1:0] victim;
		drain_requests();
		victim = CFG_W'($urandom);
		write_policy(1'b0);
		write_reg(CFG_VICTIM_SLOT, victim);
		run_random(200, 55);
	endtask

	task automatic test_victim_overwrite(logic [SLOT_W-1:0] victim, int count);
		drain_requests();
		write_policy(1'b1);
		write_reg(CFG_VICTIM_SLOT, victim);
		run_random(count, 60);
	endtask

	always @(negedge clk)
		out_ready <= ($urandom_range(99) >= recv_idle_pct);

	function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			mismatch_count++;
			$error("%s: expected %0h, got %0h", name, want, got);
		end
	endfunction

	always @(posedge clk) begin : result_check
		cache_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				mismatch_count++;
				$error("result transaction with no request outstanding");
			end else begin
				want = expected_results.pop_front();
				check_field("status", 64'(want.status), 64'(status));
				check_field("slot", 64'(want.slot), 64'(slot));
				check_field("found_ref", 64'(want.found_ref), 64'(found_ref));
				check_field("found_len", 64'(want.found_len), 64'(found_len));
				check_field("evicted", 64'(want.evicted), 64'(evicted));
				check_field("free_count", 64'(want.free_count), 64'(free_count));
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en) begin
			stall_cycles <= 0;
		end else if (stall_cycles == STALL_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = CFG_FULL_POLICY;
		cfg_wdata = '0;
		in_valid = 1'b0;
		req_type = REQ_INSERT;
		sess_id = '0;
		psk_ref = '0;
		psk_len = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_idle_pct = 21;
		recv_idle_pct = 85;
		test_empty_table_cases();
		test_fill_until_full();

		send_idle_pct = 85;
		recv_idle_pct = 21;
		test_full_refusal();
		test_victim_overwrite('0, 125);
		test_victim_overwrite('1, 125);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_victim_overwrite(SLOT_W'($urandom), 125);
		test_victim_overwrite(SLOT_W'($urandom), 125);

		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

`default_nettype wire
